FILE: rtl/lprd_pkg.sv
// lprd_pkg: shared types, codes and limits of the length-prefixed request deframer
// used by every module under rtl; depends on nothing
`timescale 1ns / 1ps

package lprd_pkg;

  // hard bounds on the configured limits
  localparam logic [31:0] MSG_BOUND  = 32'd65536;
  localparam logic [31:0] ARGS_BOUND = 32'd65535;

  // length and count headers are four bytes
  localparam logic [16:0] HDR_BYTES = 17'd4;

  // config register reset values
  localparam logic [16:0] MAX_MSG_RESET  = 17'd4096;
  localparam logic [15:0] MAX_ARGS_RESET = 16'd1024;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_COUNT   = 3'd1,
    PH_ALEN    = 3'd2,
    PH_PAYLOAD = 3'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_MARKER  = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_TRAILING  = 3'd5
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [15:0] arg_number;
    logic        arg_end;
    status_t     status;
  } result_t;

  // results caused by one accepted request, packed from slot 0
  typedef struct packed {
    logic [1:0]       count;
    result_t [1:0]    r;
  } pair_t;

  typedef struct packed {
    logic [16:0] max_message_bytes;
    logic [15:0] max_arguments;
  } cfg_t;

  function automatic result_t mk_result(kind_t k, logic [7:0] p, logic [15:0] a,
                                        logic e, status_t s);
    result_t x;
    x.kind       = k;
    x.payload    = p;
    x.arg_number = a;
    x.arg_end    = e;
    x.status     = s;
    return x;
  endfunction

endpackage

FILE: rtl/lprd_cfg.sv
// lprd_cfg: APB-style register file holding the message and argument limits
// depends on lprd_pkg
`timescale 1ns / 1ps

module lprd_cfg
  import lprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [16:0] max_message_bytes;
  logic [15:0] max_arguments;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= MAX_MSG_RESET;
      max_arguments     <= MAX_ARGS_RESET;
    end else if (wr_en) begin
      // word address only, low address bits are ignored
      if (paddr[2]) begin
        max_arguments <= pwdata[15:0];
      end else begin
        max_message_bytes <= pwdata[16:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {16'd0, max_arguments};
    end else begin
      prdata = {15'd0, max_message_bytes};
    end
  end

  assign cfg.max_message_bytes = max_message_bytes;
  assign cfg.max_arguments     = max_arguments;

endmodule

FILE: rtl/lprd_parser.sv
// lprd_parser: frame state registers and the per-byte parse logic
// produces up to two results per request; depends on lprd_pkg
`timescale 1ns / 1ps

module lprd_parser
  import lprd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] stream_byte,
  input  logic       new_connection,
  input  cfg_t       cfg,
  output pair_t      pair
);

  phase_t      phase, phase_next;
  logic [1:0]  header_byte_count, header_byte_count_next;
  logic [31:0] header_shift, header_shift_next;
  logic [16:0] body_bytes_left, body_bytes_left_next;
  logic [15:0] args_left, args_left_next;
  logic [16:0] arg_bytes_left, arg_bytes_left_next;
  logic [15:0] current_arg, current_arg_next;
  logic        halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEN;
      header_byte_count <= '0;
      header_shift      <= '0;
      body_bytes_left   <= '0;
      args_left         <= '0;
      arg_bytes_left    <= '0;
      current_arg       <= '0;
      halted            <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      header_byte_count <= header_byte_count_next;
      header_shift      <= header_shift_next;
      body_bytes_left   <= body_bytes_left_next;
      args_left         <= args_left_next;
      arg_bytes_left    <= arg_bytes_left_next;
      current_arg       <= current_arg_next;
      halted            <= halted_next;
    end
  end

  always_comb begin
    logic [31:0] v;
    logic [31:0] msg_lim;
    logic [31:0] args_lim;
    logic        slot;
    logic        close;
    logic        do_next;
    logic        last;

    phase_next             = phase;
    header_byte_count_next = header_byte_count;
    header_shift_next      = header_shift;
    body_bytes_left_next   = body_bytes_left;
    args_left_next         = args_left;
    arg_bytes_left_next    = arg_bytes_left;
    current_arg_next       = current_arg;
    halted_next            = halted;

    pair    = '0;
    slot    = 1'b0;
    close   = 1'b0;
    do_next = 1'b0;
    last    = 1'b0;
    v       = header_shift;

    msg_lim  = ({15'd0, cfg.max_message_bytes} < MSG_BOUND) ?
               {15'd0, cfg.max_message_bytes} : MSG_BOUND;
    args_lim = ({16'd0, cfg.max_arguments} < ARGS_BOUND) ?
               {16'd0, cfg.max_arguments} : ARGS_BOUND;

    // a fresh connection clears everything, this byte then parses normally
    if (new_connection) begin
      phase_next             = PH_LEN;
      header_byte_count_next = '0;
      header_shift_next      = '0;
      body_bytes_left_next   = '0;
      args_left_next         = '0;
      arg_bytes_left_next    = '0;
      current_arg_next       = '0;
      halted_next            = 1'b0;
    end

    if (!halted_next) begin
      if (phase_next == PH_PAYLOAD) begin
        last = (arg_bytes_left_next == 17'd1);
        pair.r[0] = mk_result(KIND_PAYLOAD, stream_byte, current_arg_next, last, ST_OK);
        pair.count = 2'd1;
        slot = 1'b1;
        arg_bytes_left_next  = arg_bytes_left_next - 17'd1;
        body_bytes_left_next = body_bytes_left_next - 17'd1;
        close = last;
      end else begin
        v = header_shift_next | (32'(stream_byte) << {header_byte_count_next, 3'b000});
        if (phase_next != PH_LEN) begin
          body_bytes_left_next = body_bytes_left_next - 17'd1;
        end
        if (header_byte_count_next != 2'd3) begin
          header_byte_count_next = header_byte_count_next + 2'd1;
          header_shift_next      = v;
        end else begin
          header_byte_count_next = '0;
          header_shift_next      = '0;
          case (phase_next)
            PH_LEN: begin
              if (v > msg_lim) begin
                pair.r[0] = mk_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_TOO_LONG);
                pair.count = 2'd1;
                halted_next = 1'b1;
              end else if (v < 32'(HDR_BYTES)) begin
                pair.r[0] = mk_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_SHORT);
                pair.count = 2'd1;
                halted_next = 1'b1;
              end else begin
                body_bytes_left_next = v[16:0];
                phase_next           = PH_COUNT;
              end
            end
            PH_COUNT: begin
              if (v > args_lim) begin
                pair.r[0] = mk_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_TOO_MANY);
                pair.count = 2'd1;
                halted_next = 1'b1;
              end else begin
                args_left_next   = v[15:0];
                current_arg_next = '0;
                do_next          = 1'b1;
              end
            end
            PH_ALEN: begin
              if (v > {15'd0, body_bytes_left_next}) begin
                pair.r[0] = mk_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_OVERRUN);
                pair.count = 2'd1;
                halted_next = 1'b1;
              end else if (v == 32'd0) begin
                // empty argument gives a single marker
                pair.r[0] = mk_result(KIND_MARKER, 8'd0, current_arg_next, 1'b1, ST_OK);
                pair.count = 2'd1;
                slot  = 1'b1;
                close = 1'b1;
              end else begin
                arg_bytes_left_next = v[16:0];
                phase_next          = PH_PAYLOAD;
              end
            end
            default: begin
              phase_next = PH_LEN;
            end
          endcase
        end
      end

      if (close) begin
        current_arg_next = current_arg_next + 16'd1;
        args_left_next   = args_left_next - 16'd1;
        do_next          = 1'b1;
      end

      // no argument in progress: end the message or expect the next header
      if (do_next) begin
        if (args_left_next == 16'd0) begin
          if (body_bytes_left_next != 17'd0) begin
            pair.r[slot] = mk_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_TRAILING);
            halted_next  = 1'b1;
          end else begin
            pair.r[slot]           = mk_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_OK);
            phase_next             = PH_LEN;
            header_byte_count_next = '0;
            header_shift_next      = '0;
            current_arg_next       = '0;
          end
          pair.count = pair.count + 2'd1;
        end else if (body_bytes_left_next < HDR_BYTES) begin
          pair.r[slot] = mk_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_OVERRUN);
          pair.count   = pair.count + 2'd1;
          halted_next  = 1'b1;
        end else begin
          phase_next             = PH_ALEN;
          header_byte_count_next = '0;
          header_shift_next      = '0;
        end
      end
    end

    if (!accept) begin
      pair.count = 2'd0;
    end
  end

endmodule

FILE: rtl/lprd_queue.sv
// lprd_queue: small result queue taking up to two results a cycle, giving one
// depends on lprd_pkg
`timescale 1ns / 1ps

module lprd_queue
  import lprd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  pair_t          pair,
  input  logic           pop,
  output result_t        head,
  output logic           head_valid,
  output logic [QAW:0]   level
);

  result_t        entries [QDEPTH];
  logic [QAW-1:0] rd_ptr;
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + QAW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      wr_ptr <= wr_ptr + QAW'(pair.count);
      level  <= level + (QAW+1)'(pair.count) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pair.count != 2'd0) begin
      entries[wr_ptr] <= pair.r[0];
    end
    if (pair.count == 2'd2) begin
      entries[wr_ptr_plus1] <= pair.r[1];
    end
  end

  assign head_valid = (level != '0);
  assign head       = entries[rd_ptr];

endmodule

FILE: rtl/length_prefixed_request_deframer_unit.sv
// length_prefixed_request_deframer_unit: top level of the request deframer
// depends on lprd_pkg, lprd_cfg, lprd_parser, lprd_queue
//
// Usage:
//   Input channel (in_valid/in_ready) carries one stream byte per request with
//   new_connection, which clears the parser and any halt before the byte parses.
//   Output channel (out_valid/out_ready) carries results: payload bytes with
//   their argument index, empty-argument markers and one done per message.
//   The APB-style port sets max_message_bytes (0x0) and max_arguments (0x4);
//   write it only while the block is idle.
// Results are registered in the result queue before they are offered.
// Throughput: one byte per cycle while in_ready is high. The parse is a single
//   pass of logic on the frame counters; a byte closing an argument can give
//   two results, which drain one per cycle while out_ready is high through a
//   four-entry result queue; in_ready drops while under two entries are free.
// Reset: limits return to 4096 bytes and 1024 arguments, the parser waits for
//   a message length and the queue empties.
// Stall: while out_ready is low results stay in the queue; once it fills,
//   in_ready goes low and no byte is lost. After an error no results come
//   until reset or a byte flagged new_connection.
`timescale 1ns / 1ps

module length_prefixed_request_deframer_unit
  import lprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        new_connection,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload,
  output logic [15:0] arg_number,
  output logic        arg_end,
  output logic [2:0]  status
);

  cfg_t         cfg;
  pair_t        pair;
  result_t      head;
  logic         head_valid;
  logic [QAW:0] level;
  logic         accept;
  logic         pop;

  assign in_ready = (level <= (QAW+1)'(QDEPTH - 2));
  assign accept   = in_valid && in_ready;
  assign pop      = head_valid && out_ready;

  lprd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lprd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .stream_byte    (stream_byte),
    .new_connection (new_connection),
    .cfg            (cfg),
    .pair           (pair)
  );

  lprd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .pair       (pair),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (level)
  );

  assign out_valid  = head_valid;
  assign kind       = head.kind;
  assign payload    = head.payload;
  assign arg_number = head.arg_number;
  assign arg_end    = head.arg_end;
  assign status     = head.status;

`ifndef ASSERT_OFF
  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (QAW+1)'(QDEPTH))
    else $error("result queue overflow");

  // only an accepted request produces results
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    (pair.count != 2'd0) |-> accept)
    else $error("results without an accepted request");

  // a second result from one byte is always a done
  a_second_is_done: assert property (@(posedge clk) disable iff (rst)
    (pair.count == 2'd2) |-> (pair.r[1].kind == KIND_DONE))
    else $error("second result is not a done");

  // pushed results raise the level on the next cycle when nothing pops
  a_level_step: assert property (@(posedge clk) disable iff (rst)
    (pair.count != 2'd0 && !pop) |=> (level != '0))
    else $error("queue level did not follow a push");
`endif

endmodule

FILE: verif/length_prefixed_request_deframer_unit_tb.sv
// length_prefixed_request_deframer_unit_tb: random and directed check of the request deframer
// drives byte requests and limit writes, predicts each result in-bench; depends on lprd_pkg
`timescale 1ns / 1ps

module length_prefixed_request_deframer_unit_tb;
  import lprd_pkg::*;

  localparam int REG_MAX_MSG      = 0;
  localparam int REG_MAX_ARGS     = 1;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       fresh;
  } stream_req_t;

  typedef enum int {
    MSG_OK, MSG_TOO_LONG, MSG_SHORT, MSG_TOO_MANY, MSG_OVERRUN_HDR,
    MSG_OVERRUN_LEN, MSG_TRAILING, MSG_CUT
  } msg_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte = '0;
  logic        new_connection = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  kind;
  logic [7:0]  payload;
  logic [15:0] arg_number;
  logic        arg_end;
  logic [2:0]  status;

  length_prefixed_request_deframer_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .stream_byte(stream_byte), .new_connection(new_connection),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .payload(payload), .arg_number(arg_number), .arg_end(arg_end),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // limit mirror and parser mirror
  logic [16:0] lim_msg = MAX_MSG_RESET;
  logic [15:0] lim_args = MAX_ARGS_RESET;
  phase_t      frame_phase = PH_LEN;
  logic [1:0]  hdr_count = '0;
  logic [31:0] hdr_word = '0;
  logic [16:0] body_left = '0;
  logic [15:0] args_pending = '0;
  logic [16:0] arg_left = '0;
  logic [15:0] arg_index = '0;
  logic        stopped = 1'b0;

  result_t     awaited_results[$];
  stream_req_t stream_backlog[$];
  stream_req_t next_req;
  logic [7:0]  frame_bytes[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  recv_hold = 0;
  int  send_idle_pct = 25;
  int  recv_idle_pct = 25;
  int  items_queued = 0;
  bit  calm = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  need_fresh = 1'b0;

  function automatic int msg_cap();
    return (32'(lim_msg) < MSG_BOUND) ? int'(lim_msg) : int'(MSG_BOUND);
  endfunction

  function automatic int arg_cap();
    return (32'(lim_args) < ARGS_BOUND) ? int'(lim_args) : int'(ARGS_BOUND);
  endfunction

  function automatic void expect_result(kind_t k, logic [7:0] data, logic [15:0] idx,
                                        logic last, status_t st);
    result_t r;
    r.kind       = k;
    r.payload    = data;
    r.arg_number = idx;
    r.arg_end    = last;
    r.status     = st;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic void restart_frame();
    frame_phase  = PH_LEN;
    hdr_count    = '0;
    hdr_word     = '0;
    body_left    = '0;
    args_pending = '0;
    arg_left     = '0;
    arg_index    = '0;
    stopped      = 1'b0;
  endfunction

  function automatic void abort_message(status_t st);
    expect_result(KIND_DONE, 8'd0, 16'd0, 1'b0, st);
    stopped = 1'b1;
  endfunction

  // no argument open: either the message is complete or another length header follows
  function automatic void next_argument();
    if (args_pending == 0) begin
      if (body_left != 0) begin
        abort_message(ST_TRAILING);
      end else begin
        expect_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ST_OK);
        frame_phase = PH_LEN;
        arg_index   = '0;
      end
    end else if (body_left < HDR_BYTES) begin
      abort_message(ST_OVERRUN);
    end else begin
      frame_phase = PH_ALEN;
    end
    hdr_count = '0;
    hdr_word  = '0;
  endfunction

  function automatic void close_argument();
    arg_index = arg_index + 16'd1;
    args_pending--;
    next_argument();
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic fresh);
    logic [31:0] v;
    logic        last;
    if (fresh) restart_frame();
    if (stopped) return;
    if (frame_phase == PH_PAYLOAD) begin
      last = (arg_left == 17'd1);
      expect_result(KIND_PAYLOAD, b, arg_index, last, ST_OK);
      arg_left--;
      body_left--;
      if (last) close_argument();
      return;
    end
    hdr_word |= 32'(b) << (8 * hdr_count);
    if (frame_phase != PH_LEN) body_left--;
    if (hdr_count < 2'd3) begin
      hdr_count++;
      return;
    end
    v = hdr_word;
    hdr_count = '0;
    hdr_word = '0;
    case (frame_phase)
      PH_LEN: begin
        if (v > msg_cap()) abort_message(ST_TOO_LONG);
        else if (v < 32'(HDR_BYTES)) abort_message(ST_SHORT);
        else begin
          body_left = v[16:0];
          frame_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (v > arg_cap()) abort_message(ST_TOO_MANY);
        else begin
          args_pending = v[15:0];
          arg_index = '0;
          next_argument();
        end
      end
      default: begin
        if (v > 32'(body_left)) abort_message(ST_OVERRUN);
        else if (v == 0) begin
          expect_result(KIND_MARKER, 8'd0, arg_index, 1'b1, ST_OK);
          close_argument();
        end else begin
          arg_left = v[16:0];
          frame_phase = PH_PAYLOAD;
        end
      end
    endcase
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endfunction

  // sender: predicts on every accepted request, then loads the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(stream_byte, new_connection);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (stream_backlog.size() > 0) begin
          next_req = stream_backlog.pop_front();
          in_valid <= 1'b1;
          stream_byte <= next_req.data;
          new_connection <= next_req.fresh;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each accepted result and throttles out_ready
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf(
            "unexpected result: kind %0d payload %02h arg %0d end %0b status %0d",
            kind, payload, arg_number, arg_end, status));
        end else begin
          if (kind !== awaited_results[0].kind || payload !== awaited_results[0].payload ||
              arg_number !== awaited_results[0].arg_number ||
              arg_end !== awaited_results[0].arg_end || status !== awaited_results[0].status)
            report_mismatch($sformatf(
              "expected kind %0d payload %02h arg %0d end %0b status %0d, got %0d %02h %0d %0b %0d",
              awaited_results[0].kind, awaited_results[0].payload, awaited_results[0].arg_number,
              awaited_results[0].arg_end, awaited_results[0].status,
              kind, payload, arg_number, arg_end, status));
          void'(awaited_results.pop_front());
        end
      end
      if (long_hold_req) begin
        recv_hold = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (recv_hold > 0) begin
        recv_hold = recv_hold - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < recv_idle_pct) begin
        recv_hold = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("length_prefixed_request_deframer_unit: mismatch");
      $finish;
    end
  end

  task automatic write_limit(input int index, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_MAX_MSG) lim_msg = value[16:0];
    else lim_args = value[15:0];
    want = (index == REG_MAX_MSG) ? 32'(lim_msg) : 32'(lim_args);
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== want)
      report_mismatch($sformatf("limit %0d readback %0h, expected %0h", index, readback, want));
  endtask

  function automatic void add_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) frame_bytes.insert(frame_bytes.size(), w[8*i +: 8]);
  endfunction

  // moves the first n built bytes to the backlog; a stream after an error reopens the connection
  function automatic void send_frame(int n);
    bit fresh;
    fresh = need_fresh || ($urandom_range(9) == 0);
    for (int i = 0; i < n && i < frame_bytes.size(); i++) begin
      stream_backlog.insert(stream_backlog.size(),
                            '{data: frame_bytes[i], fresh: (i == 0) && fresh});
      items_queued++;
    end
    frame_bytes.delete();
    need_fresh = 1'b0;
  endfunction

  function automatic void queue_message(msg_shape_t shape);
    int lens[$];
    int nargs, body, used, k, len;
    logic [31:0] word;
    nargs = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    if (nargs > arg_cap()) nargs = arg_cap();
    body = 4;
    for (int i = 0; i < nargs; i++) begin
      case ($urandom_range(19))
        0: len = $urandom_range(21, 300);
        1, 2, 3, 4, 5: len = $urandom_range(5, 20);
        default: len = $urandom_range(0, 4);
      endcase
      lens.insert(lens.size(), len);
      body += 4 + len;
    end
    while (body > msg_cap()) body -= 4 + lens.pop_back();
    nargs = lens.size();
    if (nargs == 0 && (shape == MSG_OVERRUN_HDR || shape == MSG_OVERRUN_LEN)) shape = MSG_OK;
    if (shape == MSG_TRAILING && body >= msg_cap()) shape = MSG_OK;
    k = (nargs > 0) ? $urandom_range(0, nargs - 1) : 0;

    case (shape)
      MSG_TOO_LONG: begin
        if ($urandom_range(3) == 0) add_word($urandom | 32'h8000_0000);
        else add_word(msg_cap() + 1 + $urandom_range(0, 3));
      end
      MSG_SHORT: add_word($urandom_range(0, 3));
      MSG_TOO_MANY: begin
        add_word(body);
        if ($urandom_range(3) == 0) add_word($urandom | 32'h0001_0000);
        else add_word(arg_cap() + 1 + $urandom_range(0, 3));
      end
      default: begin
        word = body;
        if (shape == MSG_TRAILING)
          word = body + $urandom_range(1, (msg_cap() - body > 8) ? 8 : msg_cap() - body);
        if (shape == MSG_OVERRUN_HDR) begin
          // body ends inside the header of argument k
          word = 4 + $urandom_range(0, 3);
          for (int j = 0; j < k; j++) word += 4 + lens[j];
        end
        add_word(word);
        add_word(nargs);
        used = 4;
        for (int i = 0; i < nargs; i++) begin
          if (shape == MSG_OVERRUN_HDR && i == k) break;
          used += 4;
          if (shape == MSG_OVERRUN_LEN && i == k) begin
            add_word(body - used + 1 + $urandom_range(0, 3));
            break;
          end
          add_word(lens[i]);
          repeat (lens[i]) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
          used += lens[i];
        end
      end
    endcase

    if (shape == MSG_CUT) send_frame($urandom_range(1, frame_bytes.size() - 1));
    else send_frame(frame_bytes.size());
    if (shape != MSG_OK) need_fresh = 1'b1;
    // bytes while halted are dropped by the block
    if (shape != MSG_OK && shape != MSG_CUT && $urandom_range(2) == 0)
      repeat ($urandom_range(1, 6))
        stream_backlog.insert(stream_backlog.size(), '{data: 8'($urandom), fresh: 1'b0});
  endfunction

  function automatic msg_shape_t pick_shape();
    case ($urandom_range(19))
      0: return MSG_TOO_LONG;
      1: return MSG_SHORT;
      2: return MSG_TOO_MANY;
      3: return MSG_OVERRUN_HDR;
      4: return MSG_OVERRUN_LEN;
      5: return MSG_TRAILING;
      6: return MSG_CUT;
      default: return MSG_OK;
    endcase
  endfunction

  function automatic void queue_random(int target);
    items_queued = 0;
    while (items_queued < target) queue_message(pick_shape());
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (stream_backlog.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty argument then a one-byte argument, done comes with the last byte
    add_word(32'd13);
    add_word(32'd2);
    add_word(32'd0);
    add_word(32'd1);
    frame_bytes.insert(frame_bytes.size(), 8'hFF);
    send_frame(frame_bytes.size());
    // too long, then short, then too many arguments, the last two each on a fresh connection
    add_word(32'hFFFF_FFFF);
    send_frame(4);
    need_fresh = 1'b1;
    add_word(32'd3);
    send_frame(4);
    need_fresh = 1'b1;
    add_word(32'd4);
    add_word(32'(MAX_ARGS_RESET) + 32'd1);
    send_frame(8);
    need_fresh = 1'b1;
    queue_random(400);
    wait_drained();

    write_limit(REG_MAX_MSG, 32'd65536);
    write_limit(REG_MAX_ARGS, 32'd65535);
    send_idle_pct = 40;
    recv_idle_pct = 40;
    queue_random(400);
    long_hold_req = 1'b1;
    wait_drained();

    write_limit(REG_MAX_MSG, 32'd4);
    write_limit(REG_MAX_ARGS, 32'd0);
    send_idle_pct = 10;
    recv_idle_pct = 50;
    queue_random(200);
    wait_drained();

    write_limit(REG_MAX_MSG, $urandom_range(4, 300));
    write_limit(REG_MAX_ARGS, $urandom_range(0, 6));
    send_idle_pct = 60;
    recv_idle_pct = 0;
    queue_random(400);
    long_hold_req = 1'b1;
    wait_drained();

    // no idling from here on
    write_limit(REG_MAX_MSG, $urandom_range(400, 4096));
    write_limit(REG_MAX_ARGS, $urandom_range(4, 1024));
    calm = 1'b1;
    queue_random(400);
    wait_drained();

    if (mismatches == 0) begin
      $display("length_prefixed_request_deframer_unit: match");
    end else begin
      $display("length_prefixed_request_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lprd_pkg.sv
rtl/lprd_cfg.sv
rtl/lprd_parser.sv
rtl/lprd_queue.sv
rtl/length_prefixed_request_deframer_unit.sv
verif/length_prefixed_request_deframer_unit_tb.sv
